FILE: rtl/core/stt_pkg.sv
// Shared types, codes and character tables of the source text tokenizer.
`timescale 1ns / 1ps
package stt_pkg;

    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int MAX_RECS        = 4;
    localparam int KW_COUNT        = 12;

    typedef enum logic [3:0] {
        M_IDLE, M_PEND, M_CR, M_LINEC, M_BLOCK, M_BSTAR, M_STR,
        M_SESC, M_INT, M_DOT, M_FRAC, M_IDENT, M_REPLAY, M_ERROR
    } t_mode;

    typedef enum logic [1:0] {
        REC_VALUE = 2'd0,
        REC_TOKEN = 2'd1,
        REC_ERROR = 2'd2
    } t_rtype;

    typedef enum logic [1:0] {
        ERR_UNEXPECTED = 2'd0,
        ERR_COMMENT    = 2'd1,
        ERR_STRING     = 2'd2
    } t_err;

    typedef struct packed {
        logic       take;
        logic [1:0] sel;
    } t_ctl;

    typedef struct packed {
        logic [KW_COUNT-1:0] cand;
        logic [2:0]          len;
    } t_kw;

    localparam logic [5:0] K_ARROW   = 6'd0;
    localparam logic [5:0] K_EQEQ    = 6'd1;
    localparam logic [5:0] K_BANGEQ  = 6'd2;
    localparam logic [5:0] K_LE      = 6'd3;
    localparam logic [5:0] K_GE      = 6'd4;
    localparam logic [5:0] K_PLUSEQ  = 6'd5;
    localparam logic [5:0] K_MINUSEQ = 6'd6;
    localparam logic [5:0] K_STAREQ  = 6'd7;
    localparam logic [5:0] K_SLASHEQ = 6'd8;
    localparam logic [5:0] K_DOT     = 6'd20;
    localparam logic [5:0] K_STRING  = 6'd25;
    localparam logic [5:0] K_INT     = 6'd26;
    localparam logic [5:0] K_FRAC    = 6'd27;
    localparam logic [5:0] K_FLOAT   = 6'd28;
    localparam logic [5:0] K_IDENT   = 6'd29;
    localparam logic [5:0] K_KW0     = 6'd30;
    localparam logic [5:0] K_NEWLINE = 6'd42;
    localparam logic [5:0] K_EOF     = 6'd43;
    localparam logic [5:0] K_NONE    = 6'd63;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"f", "u", "n", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"c", "l", "a", "s", "s", CH_NUL, CH_NUL, CH_NUL},
        '{"v", "a", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"v", "a", "l", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"e", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"w", "h", "i", "l", "e", CH_NUL, CH_NUL, CH_NUL},
        '{"r", "e", "t", "u", "r", "n", CH_NUL, CH_NUL},
        '{"p", "r", "i", "n", "t", CH_NUL, CH_NUL, CH_NUL},
        '{"t", "r", "u", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"f", "a", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL},
        '{"N", "o", "n", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd3, 3'd3, 3'd2, 3'd4, 3'd5, 3'd6, 3'd5, 3'd4, 3'd5, 3'd4
    };

    function automatic logic f_is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic f_is_word(input logic [7:0] b);
        return f_is_alpha(b) || f_is_digit(b) || (b == "_");
    endfunction

    function automatic logic f_is_lead(input logic [7:0] b);
        return b inside {"-", "=", "!", "<", ">", "+", "*", "/"};
    endfunction

    function automatic logic [5:0] f_single_kind(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            "(":     k = 6'd9;
            ")":     k = 6'd10;
            "{":     k = 6'd11;
            "}":     k = 6'd12;
            ",":     k = 6'd13;
            "+":     k = 6'd14;
            "-":     k = 6'd15;
            "*":     k = 6'd16;
            "/":     k = 6'd17;
            "=":     k = 6'd18;
            ":":     k = 6'd19;
            ".":     k = K_DOT;
            "[":     k = 6'd21;
            "]":     k = 6'd22;
            "<":     k = 6'd23;
            ">":     k = 6'd24;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] f_pair_kind(input logic [7:0] h, input logic [7:0] b);
        logic [5:0] k;
        k = K_NONE;
        if ((h == "-") && (b == ">")) begin
            k = K_ARROW;
        end else if (b == "=") begin
            case (h)
                "=":     k = K_EQEQ;
                "!":     k = K_BANGEQ;
                "<":     k = K_LE;
                ">":     k = K_GE;
                "+":     k = K_PLUSEQ;
                "-":     k = K_MINUSEQ;
                "*":     k = K_STAREQ;
                "/":     k = K_SLASHEQ;
                default: k = K_NONE;
            endcase
        end
        return k;
    endfunction

    function automatic t_kw f_kw_step(input t_kw kw, input logic [7:0] b);
        t_kw r;
        r = kw;
        for (int i = 0; i < KW_COUNT; i++) begin
            if ((kw.len >= KW_LEN[i]) || (KW_TEXT[i][kw.len] != b)) begin
                r.cand[i] = 1'b0;
            end
        end
        r.len = (kw.len < 3'd7) ? kw.len + 3'd1 : 3'd7;
        return r;
    endfunction

    function automatic logic [5:0] f_kw_kind(input t_kw kw);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (kw.cand[i] && (KW_LEN[i] == kw.len)) begin
                k = K_KW0 + 6'(i);
            end
        end
        return k;
    endfunction

endpackage

FILE: rtl/core/stt_in_if.sv
// Source byte channel: valid, ready and one source byte or end mark per beat.
`timescale 1ns / 1ps
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_source;

    modport source (output valid, output source_byte, output end_of_source, input ready);
    modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

FILE: rtl/core/stt_out_if.sv
// Record channel: valid, ready and one value, token or error record per beat.
`timescale 1ns / 1ps
interface stt_out_if #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             record_type;
    logic [7:0]             value_byte;
    logic [5:0]             token_kind;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;
    logic [1:0]             error_code;
    logic                   last_of_run;

    modport source (
        output valid, output record_type, output value_byte, output token_kind,
        output start_line, output start_column, output error_code,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input record_type, input value_byte, input token_kind,
        input start_line, input start_column, input error_code,
        input last_of_run, output ready
    );
endinterface

FILE: rtl/core/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
//
//   channel  dir  beat
//   i_src    in   one source byte, or the end-of-source mark
//   o_res    out  one value, token or error record; last_of_run closes a run
//
// One source beat is scanned in the cycle it is accepted; its zero to four
// records are registered and leave one per cycle while o_res is ready, and
// a beat with records holds off the next until the record port drains them.
// The next source beat is taken in the cycle the last pending record goes.
// Reset is synchronous, active low, and needs no clearing pass.
`timescale 1ns / 1ps
module source_text_tokenizer #(
    parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stt_in_if.sink     i_src,
    stt_out_if.source  o_res
);
    import stt_pkg::*;

    logic       r_busy;
    logic [1:0] r_idx;
    logic [1:0] r_last;
    t_ctl       w_ctl;
    logic [2:0] w_count;
    logic       w_at_last;
    t_rtype     w_rtype;
    t_err       w_err;

    assign w_at_last   = (r_idx == r_last);
    assign i_src.ready = !r_busy || (o_res.ready && w_at_last);
    assign w_ctl.take  = i_src.valid && i_src.ready;
    assign w_ctl.sel   = r_idx;

    stt_scan #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_byte  (i_src.source_byte),
        .i_end   (i_src.end_of_source),
        .o_count (w_count),
        .o_rtype (w_rtype),
        .o_val   (o_res.value_byte),
        .o_kind  (o_res.token_kind),
        .o_line  (o_res.start_line),
        .o_col   (o_res.start_column),
        .o_err   (w_err)
    );

    assign o_res.valid       = r_busy;
    assign o_res.record_type = 2'(w_rtype);
    assign o_res.error_code  = 2'(w_err);
    assign o_res.last_of_run = w_at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
            r_last <= 2'd0;
        end else if (w_ctl.take) begin
            r_busy <= (w_count != 3'd0);
            r_idx  <= 2'd0;
            r_last <= 2'(w_count - 3'd1);
        end else if (r_busy && o_res.ready) begin
            if (w_at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_last))
        else $error("record index past end of run");

    a_take_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.take && r_busy) |-> (o_res.ready && w_at_last))
        else $error("source beat taken while records still pending");

    a_type_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.record_type != 2'd3))
        else $error("illegal record type");

    a_token_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (w_rtype == REC_TOKEN)) |-> (o_res.start_line != '0))
        else $error("token on line zero");

    a_run_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && o_res.ready && !w_at_last && !w_ctl.take) |=> (r_idx == $past(r_idx) + 2'd1))
        else $error("record index failed to advance");

endmodule

FILE: rtl/core/stt_scan.sv
// Scanner state, single-pass step logic and the registered record bundle.
`timescale 1ns / 1ps
module stt_scan #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  stt_pkg::t_ctl          i_ctl,
    input  logic [7:0]             i_byte,
    input  logic                   i_end,
    output logic [2:0]             o_count,
    output stt_pkg::t_rtype        o_rtype,
    output logic [7:0]             o_val,
    output logic [5:0]             o_kind,
    output logic [LINE_BITS-1:0]   o_line,
    output logic [COLUMN_BITS-1:0] o_col,
    output stt_pkg::t_err          o_err
);
    import stt_pkg::*;

    typedef struct packed {
        logic [7:0]             held;
        t_mode                  mode;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [LINE_BITS-1:0]   tline;
        logic [COLUMN_BITS-1:0] tcol;
        t_kw                    kw;
    } t_st;

    typedef struct packed {
        t_rtype                 rtype;
        logic [7:0]             val;
        logic [5:0]             kind;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        t_err                   err;
    } t_rec;

    typedef struct packed {
        t_st                     st;
        t_rec [MAX_RECS-1:0]     recs;
        logic [2:0]              n;
    } t_ctx;

    t_st             r_st;
    t_rec [MAX_RECS-1:0] r_recs;
    t_ctx            n_ctx;

    function automatic t_st f_rst();
        t_st s;
        s.held  = '0;
        s.mode  = M_IDLE;
        s.line  = LINE_BITS'(1);
        s.col   = '0;
        s.tline = LINE_BITS'(1);
        s.tcol  = '0;
        s.kw    = '{cand: '1, len: 3'd0};
        return s;
    endfunction

    function automatic t_ctx f_put(input t_ctx c, input t_rtype rt, input logic [7:0] v,
                                   input logic [5:0] k, input logic [LINE_BITS-1:0] l,
                                   input logic [COLUMN_BITS-1:0] cl, input t_err e);
        t_ctx r;
        r = c;
        if (c.n < 3'(MAX_RECS)) begin
            r.recs[c.n[1:0]] = '{rtype: rt, val: v, kind: k, line: l, col: cl, err: e};
            r.n = c.n + 3'd1;
        end
        return r;
    endfunction

    function automatic t_ctx f_val(input t_ctx c, input logic [7:0] v);
        return f_put(c, REC_VALUE, v, 6'd0, '0, '0, ERR_UNEXPECTED);
    endfunction

    function automatic t_ctx f_tok(input t_ctx c, input logic [5:0] k);
        return f_put(c, REC_TOKEN, 8'd0, k, c.st.tline, c.st.tcol, ERR_UNEXPECTED);
    endfunction

    function automatic t_ctx f_here(input t_ctx c, input logic [5:0] k);
        return f_put(c, REC_TOKEN, 8'd0, k, c.st.line, c.st.col, ERR_UNEXPECTED);
    endfunction

    function automatic t_ctx f_fail(input t_ctx c, input t_err e);
        t_ctx r;
        r = f_put(c, REC_ERROR, 8'd0, 6'd0, c.st.line, c.st.col, e);
        r.st.mode = M_ERROR;
        return r;
    endfunction

    function automatic t_ctx f_col(input t_ctx c);
        t_ctx r;
        r = c;
        if (c.st.col != {COLUMN_BITS{1'b1}}) begin
            r.st.col = c.st.col + COLUMN_BITS'(1);
        end
        return r;
    endfunction

    function automatic t_ctx f_nl(input t_ctx c);
        t_ctx r;
        r = c;
        if (c.st.line != {LINE_BITS{1'b1}}) begin
            r.st.line = c.st.line + LINE_BITS'(1);
        end
        r.st.col = '0;
        return r;
    endfunction

    function automatic t_ctx f_mark(input t_ctx c);
        t_ctx r;
        r = c;
        r.st.tline = c.st.line;
        r.st.tcol  = c.st.col;
        return r;
    endfunction

    function automatic t_ctx f_idle(input t_ctx c, input logic [7:0] b);
        t_ctx r;
        r = c;
        r.st.mode = M_IDLE;
        if ((b == " ") || (b == CH_TAB)) begin
            r = f_col(r);
        end else if ((b == CH_LF) || (b == CH_CR)) begin
            r = f_nl(r);
            r = f_val(r, CH_LF);
            r = f_here(r, K_NEWLINE);
            if (b == CH_CR) begin
                r.st.mode = M_CR;
            end
        end else if (f_is_lead(b)) begin
            r = f_mark(r);
            r.st.held = b;
            r.st.mode = M_PEND;
        end else if (f_single_kind(b) != K_NONE) begin
            r = f_val(r, b);
            r = f_here(r, f_single_kind(b));
            r = f_col(r);
        end else if (b == "\"") begin
            r = f_mark(r);
            r = f_col(r);
            r.st.mode = M_STR;
        end else if (f_is_digit(b)) begin
            r = f_mark(r);
            r = f_val(r, b);
            r = f_col(r);
            r.st.mode = M_INT;
        end else if (f_is_alpha(b) || (b == "_")) begin
            r = f_mark(r);
            r.st.kw = f_kw_step('{cand: '1, len: 3'd0}, b);
            r = f_val(r, b);
            r = f_col(r);
            r.st.mode = M_IDENT;
        end else begin
            r = f_fail(r, ERR_UNEXPECTED);
        end
        return r;
    endfunction

    function automatic t_ctx f_feed(input t_ctx c, input logic [7:0] b);
        t_ctx       r;
        logic [7:0] h;
        logic [5:0] k;
        r = c;
        h = c.st.held;
        k = f_pair_kind(h, b);
        case (c.st.mode)
            M_CR: begin
                r.st.mode = M_IDLE;
                if (b != CH_LF) begin
                    r = f_idle(r, b);
                end
            end
            M_PEND: begin
                r.st.mode = M_IDLE;
                if ((h == "/") && ((b == "/") || (b == "*"))) begin
                    r = f_col(f_col(r));
                    r.st.mode = (b == "/") ? M_LINEC : M_BLOCK;
                end else if (k != K_NONE) begin
                    r = f_val(r, h);
                    r = f_val(r, b);
                    r = f_tok(r, k);
                    r = f_col(f_col(r));
                end else if (h == "!") begin
                    r = f_fail(r, ERR_UNEXPECTED);
                end else begin
                    r = f_val(r, h);
                    r = f_tok(r, f_single_kind(h));
                    r = f_col(r);
                    r = f_idle(r, b);
                end
            end
            M_LINEC: begin
                if (b == CH_LF) begin
                    r = f_idle(r, b);
                end else begin
                    r = f_col(r);
                end
            end
            M_BLOCK, M_BSTAR: begin
                if ((c.st.mode == M_BSTAR) && (b == "/")) begin
                    r = f_col(r);
                    r.st.mode = M_IDLE;
                end else if (b == "*") begin
                    r = f_col(r);
                    r.st.mode = M_BSTAR;
                end else begin
                    r = (b == CH_LF) ? f_nl(r) : f_col(r);
                    r.st.mode = M_BLOCK;
                end
            end
            M_STR: begin
                if (b == "\"") begin
                    r = f_tok(r, K_STRING);
                    r = f_col(r);
                    r.st.mode = M_IDLE;
                end else if (b == CH_LF) begin
                    r = f_fail(r, ERR_STRING);
                end else if (b == "\\") begin
                    r = f_col(r);
                    r.st.mode = M_SESC;
                end else begin
                    r = f_val(r, b);
                    r = f_col(r);
                end
            end
            M_SESC: begin
                r = f_val(r, (b == "n") ? CH_LF : ((b == "t") ? CH_TAB : b));
                r = f_col(r);
                r.st.mode = M_STR;
            end
            M_INT, M_FRAC: begin
                if (f_is_digit(b)) begin
                    r = f_val(r, b);
                    r = f_col(r);
                end else if ((c.st.mode == M_INT) && (b == ".")) begin
                    r.st.held = b;
                    r.st.mode = M_DOT;
                end else if ((b == "f") || (b == "F")) begin
                    r = f_tok(r, K_FLOAT);
                    r = f_col(r);
                    r.st.mode = M_IDLE;
                end else begin
                    r = f_tok(r, (c.st.mode == M_INT) ? K_INT : K_FRAC);
                    r = f_idle(r, b);
                end
            end
            M_DOT: begin
                if (f_is_digit(b)) begin
                    r = f_val(r, ".");
                    r = f_val(r, b);
                    r = f_col(f_col(r));
                    r.st.mode = M_FRAC;
                end else begin
                    r = f_tok(r, K_INT);
                    r = f_val(r, ".");
                    r = f_here(r, K_DOT);
                    r = f_col(r);
                    r.st.held = b;
                    r.st.mode = M_REPLAY;
                end
            end
            M_IDENT: begin
                if (f_is_word(b)) begin
                    r.st.kw = f_kw_step(c.st.kw, b);
                    r = f_val(r, b);
                    r = f_col(r);
                end else begin
                    r = f_tok(r, f_kw_kind(c.st.kw));
                    r = f_idle(r, b);
                end
            end
            M_ERROR: begin
                r = c;
            end
            default: begin
                r = f_idle(r, b);
            end
        endcase
        return r;
    endfunction

    function automatic t_ctx f_finish(input t_ctx c);
        t_ctx r;
        logic eof;
        r   = c;
        eof = 1'b1;
        case (c.st.mode)
            M_PEND: begin
                if (c.st.held == "!") begin
                    r   = f_fail(r, ERR_UNEXPECTED);
                    eof = 1'b0;
                end else begin
                    r = f_val(r, c.st.held);
                    r = f_tok(r, f_single_kind(c.st.held));
                    r = f_col(r);
                end
            end
            M_BLOCK, M_BSTAR: begin
                r   = f_fail(r, ERR_COMMENT);
                eof = 1'b0;
            end
            M_STR, M_SESC: begin
                r   = f_fail(r, ERR_STRING);
                eof = 1'b0;
            end
            M_INT:   r = f_tok(r, K_INT);
            M_FRAC:  r = f_tok(r, K_FRAC);
            M_DOT: begin
                r = f_tok(r, K_INT);
                r = f_val(r, ".");
                r = f_here(r, K_DOT);
                r = f_col(r);
            end
            M_IDENT: r = f_tok(r, f_kw_kind(c.st.kw));
            M_ERROR: eof = 1'b0;
            default: eof = 1'b1;
        endcase
        if (eof) begin
            r = f_here(r, K_EOF);
        end
        return r;
    endfunction

    always_comb begin
        t_ctx c;
        c.st   = r_st;
        c.recs = '0;
        c.n    = 3'd0;
        if (r_st.mode == M_REPLAY) begin
            c = f_idle(c, r_st.held);
        end
        if (i_end) begin
            c    = f_finish(c);
            c.st = f_rst();
        end else begin
            c = f_feed(c, i_byte);
        end
        n_ctx = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= f_rst();
        end else if (i_ctl.take) begin
            r_st <= n_ctx.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take && (n_ctx.n != 3'd0)) begin
            r_recs <= n_ctx.recs;
        end
    end

    assign o_count = n_ctx.n;
    assign o_rtype = r_recs[i_ctl.sel].rtype;
    assign o_val   = r_recs[i_ctl.sel].val;
    assign o_kind  = r_recs[i_ctl.sel].kind;
    assign o_line  = r_recs[i_ctl.sel].line;
    assign o_col   = r_recs[i_ctl.sel].col;
    assign o_err   = r_recs[i_ctl.sel].err;

endmodule
